/* hw/rtl/amrt_pkg.sv */
// Package for the adaptive mutation rate tuner.
// Holds widths, reset values, register indexes, state codes and control structs.
// No dependencies.
package amrt_pkg;

  localparam int POP_W   = 7;
  localparam int LIM_W   = 16;
  localparam int THR_W   = 31;
  localparam int RATE_W  = 16;
  localparam int FRAC_W  = 17;
  localparam int SCORE_W = 32;
  localparam int IDX_W   = 6;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 31;
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;

  localparam int MAX_POPULATION_DEF = 64;

  localparam logic [FRAC_W-1:0]  ONE_Q16  = 17'h10000;
  localparam logic [SCORE_W-1:0] Q_MIN_RST = 32'h7FFF_FFFF;

  localparam logic [CFG_IW-1:0] REG_POP    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LIMIT  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_THR    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WINDOW = 3'd3;
  localparam logic [CFG_IW-1:0] REG_RMAX   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RMIN   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SLOPE  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SMOOTH = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QDIV, ST_QWAIT, ST_FACTOR, ST_FWAIT, ST_CONV, ST_SMUL, ST_SUP,
    ST_SDIV, ST_SWAIT, ST_RD, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic q_start;
    logic factor;
    logic f_latch;
    logic conv;
    logic smul;
    logic sup;
    logic s_start;
    logic s_latch;
    logic rd;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic need_fdiv;
    logic n_zero;
    logic last_i;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/amrt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on amrt_pkg for the operand widths.
module amrt_div import amrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic [DIV_NW-1:0] quot,
  output logic [DIV_DW-1:0] rem,
  output logic              busy
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW:0]   sh;
  logic              ge;

  assign sh = {rem, quot[DIV_NW-1]};
  assign ge = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? DIV_DW'(sh - {1'b0, dvs}) : sh[DIV_DW-1:0];
      quot <= {quot[DIV_NW-2:0], ge};
    end
  end

endmodule

/* hw/rtl/amrt_ctrl.sv */
// Sequencer for the tuner: steps one generation through division, update and walk.
// Depends on amrt_pkg for state codes and the command and status structs.
module amrt_ctrl import amrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_QDIV;
      ST_QDIV:   state_next = ST_QWAIT;
      ST_QWAIT:  if (!sts.div_busy) state_next = ST_FACTOR;
      ST_FACTOR: state_next = sts.need_fdiv ? ST_FWAIT : ST_CONV;
      ST_FWAIT:  if (!sts.div_busy) state_next = ST_CONV;
      ST_CONV:   state_next = ST_SMUL;
      ST_SMUL:   state_next = ST_SUP;
      ST_SUP:    state_next = sts.n_zero ? ST_IDLE : ST_SDIV;
      ST_SDIV:   state_next = ST_SWAIT;
      ST_SWAIT:  if (!sts.div_busy) state_next = ST_RD;
      ST_RD:     state_next = ST_MUL;
      ST_MUL:    if (sts.out_free) state_next = ST_EMIT;
      ST_EMIT:   state_next = sts.last_i ? ST_IDLE : ST_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_QDIV:   cmd.q_start = 1'b1;
      ST_FACTOR: cmd.factor  = 1'b1;
      ST_FWAIT:  cmd.f_latch = !sts.div_busy;
      ST_CONV:   cmd.conv    = 1'b1;
      ST_SMUL:   cmd.smul    = 1'b1;
      ST_SUP:    cmd.sup     = 1'b1;
      ST_SDIV:   cmd.s_start = 1'b1;
      ST_SWAIT:  cmd.s_latch = !sts.div_busy;
      ST_RD:     cmd.rd      = 1'b1;
      ST_MUL:    cmd.mul     = 1'b1;
      ST_EMIT:   cmd.emit    = 1'b1;
      default:   cmd         = '0;
    endcase
  end

endmodule

/* hw/rtl/amrt_dp.sv */
// Datapath of the tuner: configuration, score state, rate table and output register.
// Depends on amrt_pkg and amrt_div.
module amrt_dp import amrt_pkg::*; #(
  parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IW-1:0]         cfg_index,
  input  logic [CFG_DW-1:0]         cfg_data,
  input  logic signed [SCORE_W-1:0] best_score,
  input  cmd_t                      cmd,
  output status_t                   sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          individual_index,
  output logic [RATE_W-1:0]         mut_count,
  output logic                      converged,
  output logic                      last
);

  localparam int AW = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;

  logic [POP_W-1:0]  pop;
  logic [LIM_W-1:0]  iter_limit, window;
  logic [THR_W-1:0]  thr;
  logic [RATE_W-1:0] rmax, rmin;
  logic [FRAC_W-1:0] slope, smooth;

  logic [LIM_W-1:0]          items_seen, stall_count;
  logic                      conv_flag;
  logic signed [SCORE_W-1:0] smoothed, prev_score, q_min, q_max, score;
  logic [DIV_DW-1:0]         abs_d;
  logic                      d_neg, d_zero, sm_zero;
  logic [FRAC_W-1:0]         factor, a_w;
  logic signed [49:0]        p1, p2;
  logic [FRAC_W-1:0]         qs, sq, sloped;
  logic [POP_W-1:0]          rs, sr, cnt, n_eff;

  logic [RATE_W-1:0] tbl [MAX_POPULATION];
  logic [MAX_POPULATION-1:0] vld;
  logic [RATE_W-1:0] rd_data;
  logic              rd_vld;
  logic [AW-1:0]     addr;

  logic              div_start;
  logic [DIV_NW-1:0] div_nd;
  logic [DIV_DW-1:0] div_ds, div_rem;
  logic [DIV_NW-1:0] div_quot;
  logic              div_busy;

  amrt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_nd), .divisor(div_ds),
    .quot(div_quot), .rem(div_rem), .busy(div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pop        <= POP_W'(64);
      iter_limit <= LIM_W'(1000);
      thr        <= THR_W'(655);
      window     <= LIM_W'(10);
      rmax       <= RATE_W'(16);
      rmin       <= RATE_W'(1);
      slope      <= '0;
      smooth     <= FRAC_W'(13107);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POP:    pop        <= cfg_data[POP_W-1:0];
        REG_LIMIT:  iter_limit <= cfg_data[LIM_W-1:0];
        REG_THR:    thr        <= cfg_data[THR_W-1:0];
        REG_WINDOW: window     <= cfg_data[LIM_W-1:0];
        REG_RMAX:   rmax       <= cfg_data[RATE_W-1:0];
        REG_RMIN:   rmin       <= cfg_data[RATE_W-1:0];
        REG_SLOPE:  slope      <= cfg_data[FRAC_W-1:0];
        REG_SMOOTH: smooth     <= cfg_data[FRAC_W-1:0];
        default:    pop        <= pop;
      endcase
    end
  end

  assign n_eff = (int'(pop) > MAX_POPULATION) ? POP_W'(MAX_POPULATION) : pop;

  // quotient and factor selection
  logic signed [SCORE_W:0]   d_full;
  logic                      q_ok, q_lt, q_gt;
  logic signed [SCORE_W-1:0] q;
  logic signed [SCORE_W:0]   q_off, q_rng;

  assign d_full = {best_score[SCORE_W-1], best_score} - {smoothed[SCORE_W-1], smoothed};
  assign q      = d_neg ? -$signed(div_quot[SCORE_W-1:0]) : $signed(div_quot[SCORE_W-1:0]);
  assign q_ok   = !d_zero && (d_neg ? (div_quot <= DIV_NW'(64'h8000_0000))
                                    : (div_quot <= DIV_NW'(64'h7FFF_FFFF)));
  assign q_lt   = q < q_min;
  assign q_gt   = q > q_max;
  assign q_off  = {q[SCORE_W-1], q} - {q_min[SCORE_W-1], q_min};
  assign q_rng  = {q_max[SCORE_W-1], q_max} - {q_min[SCORE_W-1], q_min};

  assign sts.need_fdiv = q_ok && !q_lt && !q_gt && (q_max != q_min);
  assign sts.div_busy  = div_busy;
  assign sts.n_zero    = n_eff == '0;
  assign sts.last_i    = (cnt + 1'b1) == n_eff;
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    div_start = cmd.q_start || cmd.s_start || (cmd.factor && sts.need_fdiv);
    div_nd    = DIV_NW'({thr, 16'b0});
    div_ds    = abs_d;
    if (cmd.factor) begin
      div_nd = {q_off[DIV_DW-1:0], 16'b0};
      div_ds = q_rng[DIV_DW-1:0];
    end else if (cmd.s_start) begin
      div_nd = DIV_NW'(slope);
      div_ds = DIV_DW'(n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_min <= Q_MIN_RST;
      q_max <= '0;
    end else if (cmd.factor && q_ok) begin
      if (q_lt) begin
        q_min <= q;
      end else if (q_gt) begin
        q_max <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      score   <= best_score;
      d_neg   <= d_full[SCORE_W];
      d_zero  <= d_full == '0;
      abs_d   <= d_full[SCORE_W] ? DIV_DW'(-d_full) : d_full[DIV_DW-1:0];
      sm_zero <= smoothed == '0;
    end
    if (cmd.factor) begin
      factor <= (!q_ok || (!q_lt && q_gt)) ? ONE_Q16 : '0;
    end else if (cmd.f_latch) begin
      factor <= div_quot[FRAC_W-1:0];
    end
  end

  // convergence and smoothing
  logic [LIM_W:0]   items_inc, stall_inc;
  logic [LIM_W-1:0] items_new, stall_new;
  logic [SCORE_W:0] chg, abs_chg;
  logic             stalled;
  logic [FRAC_W-1:0] a_sel;

  assign items_inc = {1'b0, items_seen} + 1'b1;
  assign items_new = items_inc[LIM_W] ? items_seen : items_inc[LIM_W-1:0];
  assign stall_inc = {1'b0, stall_count} + 1'b1;
  assign stall_new = stall_inc[LIM_W] ? stall_count : stall_inc[LIM_W-1:0];
  assign chg       = {score[SCORE_W-1], score} - {prev_score[SCORE_W-1], prev_score};
  assign abs_chg   = chg[SCORE_W] ? -chg : chg;
  assign stalled   = abs_chg < (SCORE_W+1)'(thr);
  assign a_sel     = (items_seen == '0) ? '0 : ((smooth > ONE_Q16) ? ONE_Q16 : smooth);

  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen  <= '0;
      stall_count <= '0;
      conv_flag   <= 1'b0;
      smoothed    <= '0;
      prev_score  <= '0;
    end else begin
      if (cmd.conv) begin
        items_seen  <= items_new;
        stall_count <= stalled ? stall_new : '0;
        prev_score  <= score;
        if (({1'b0, items_new} > ({1'b0, iter_limit} + 1'b1)) ||
            (stalled && (stall_new > window))) begin
          conv_flag <= 1'b1;
        end
      end
      if (cmd.sup) begin
        smoothed <= SCORE_W'((p1 + p2) >>> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      a_w <= a_sel;
      p1  <= $signed({1'b0, a_sel}) * score;
    end
    if (cmd.smul) begin
      p2 <= $signed({1'b0, ONE_Q16 - a_w}) * smoothed;
    end
  end

  // rate walk
  logic signed [FRAC_W+1:0] w_raw;
  logic [FRAC_W-1:0]        w;
  logic [33:0]              fw;
  logic signed [FRAC_W-1:0] span;
  logic signed [34:0]       prod;
  logic [RATE_W-1:0]        old_rate, new_rate;
  logic [POP_W:0]           sr_sum;

  assign addr     = AW'(cnt);
  assign w_raw    = $signed({2'b0, ONE_Q16}) - $signed({2'b0, sq});
  assign w        = w_raw[FRAC_W+1] ? '0 : w_raw[FRAC_W-1:0];
  assign fw       = factor * w;
  assign span     = $signed({1'b0, rmax}) - $signed({1'b0, rmin});
  assign prod     = $signed({1'b0, sloped}) * span;
  assign old_rate = rd_vld ? rd_data : '0;
  assign new_rate = sm_zero ? ((old_rate < rmax) ? old_rate + 1'b1 : old_rate)
                            : rmin + RATE_W'(prod >>> 16);
  assign sr_sum   = {1'b0, sr} + {1'b0, rs};

  always_ff @(posedge clk) begin
    if (cmd.s_latch) begin
      qs  <= div_quot[FRAC_W-1:0];
      rs  <= div_rem[POP_W-1:0];
      sq  <= '0;
      sr  <= '0;
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + 1'b1;
      if (sr_sum >= {1'b0, n_eff}) begin
        sr <= POP_W'(sr_sum - {1'b0, n_eff});
        sq <= sq + qs + 1'b1;
      end else begin
        sr <= sr_sum[POP_W-1:0];
        sq <= sq + qs;
      end
    end
    if (cmd.mul) begin
      sloped <= fw[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= tbl[addr];
    end
    if (cmd.emit) begin
      tbl[addr] <= new_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.rd) begin
      rd_vld <= vld[addr];
    end else if (cmd.emit) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      converged <= 1'b0;
    end else if (cmd.emit) begin
      out_valid        <= 1'b1;
      individual_index <= cnt[IDX_W-1:0];
      mut_count        <= new_rate;
      converged        <= conv_flag;
      last             <= sts.last_i;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/adaptive_mutation_rate_tuner_top.sv */
// Top level of the adaptive mutation rate tuner.
// Depends on amrt_pkg, amrt_ctrl, amrt_dp (which holds amrt_div).
//
// Usage:
//   Input channel in_valid/in_ready carries one best_score (signed Q16.16) per
//   generation. For each one the block returns population_size transactions
//   (capped at MAX_POPULATION) on out_valid/out_ready, carrying individual_index,
//   mut_count, the sticky converged flag and last on the final individual.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
//   From acceptance to the last result the block runs the quotient division,
//   the factor step, the factor's own division when it needs one, the update
//   steps (convert, smoothing multiply, smoothing update) and, unless the
//   population is zero, the slope division and then a read, a multiply and
//   an emit step for each individual. It takes no new score before it is
//   through with the last; the shared bit-serial divider and the walk set its pace.
//   in_ready is high only between generations. A stalled receiver holds the
//   output register and the walk waits on it.
//   Reset restores register defaults, clears scores, counters, the
//   convergence flag and the rate table (valid bits clear at once).
module adaptive_mutation_rate_tuner_top import amrt_pkg::*; #(
  parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IW-1:0]         cfg_index,
  input  logic [CFG_DW-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SCORE_W-1:0] best_score,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          individual_index,
  output logic [RATE_W-1:0]         mut_count,
  output logic                      converged,
  output logic                      last
);

  cmd_t    cmd;
  status_t sts;

  amrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  amrt_dp #(.MAX_POPULATION(MAX_POPULATION)) u_dp (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .best_score(best_score), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .individual_index(individual_index),
    .mut_count(mut_count), .converged(converged), .last(last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready) else $error("walk ended early");

  a_converged_sticky: assert property (@(posedge clk) disable iff (rst)
    converged |=> converged) else $error("converged flag dropped");

endmodule

/* verif/amrt_checker.sv */
`timescale 1ns / 100ps
// Checker for the adaptive mutation rate tuner: tracks register writes,
// predicts the rates for every accepted score and compares each result.
// Depends on amrt_pkg.
module amrt_checker import amrt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IW-1:0]         cfg_index,
  input  logic [CFG_DW-1:0]         cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [SCORE_W-1:0] best_score,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [IDX_W-1:0]          individual_index,
  input  logic [RATE_W-1:0]         mut_count,
  input  logic                      converged,
  input  logic                      last,
  output int                        errors,
  output int                        pending
);

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [RATE_W-1:0] rate;
    logic              conv;
    logic              fin;
  } rate_rec_t;

  rate_rec_t rate_q[$];

  longint pop_r, lim_r, thr_r, win_r, rmax_r, rmin_r, slope_r, smooth_r;
  longint gens, stalls, smoothed, prev_score, q_lo, q_hi;
  logic   conv_flag;
  logic [RATE_W-1:0] rates [MAX_POPULATION_DEF];

  assign pending = rate_q.size();

  task automatic clear_state();
    pop_r = 64; lim_r = 1000; thr_r = 655; win_r = 10;
    rmax_r = 16; rmin_r = 1; slope_r = 0; smooth_r = 13107;
    gens = 0; stalls = 0; conv_flag = 0; smoothed = 0; prev_score = 0;
    q_lo = 64'sh7FFF_FFFF; q_hi = 0;
    foreach (rates[i]) rates[i] = '0;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_POP:    pop_r    = val[6:0];
      REG_LIMIT:  lim_r    = val[15:0];
      REG_THR:    thr_r    = val[30:0];
      REG_WINDOW: win_r    = val[15:0];
      REG_RMAX:   rmax_r   = val[15:0];
      REG_RMIN:   rmin_r   = val[15:0];
      REG_SLOPE:  slope_r  = val[16:0];
      REG_SMOOTH: smooth_r = val[16:0];
      default: ;
    endcase
  endtask

  task automatic predict_rates(logic signed [SCORE_W-1:0] score_in);
    longint sc, n, factor, d, q, w, sloped, span, rate, change, a;
    rate_rec_t r;
    sc = score_in;
    n = (pop_r > MAX_POPULATION_DEF) ? MAX_POPULATION_DEF : pop_r;
    factor = 65536;
    d = sc - smoothed;
    if (d != 0) begin
      q = (thr_r * 65536) / d;
      if (q >= -64'sd2147483648 && q <= 64'sd2147483647) begin
        if (q < q_lo) begin
          q_lo = q;
          factor = 0;
        end else if (q > q_hi) begin
          q_hi = q;
          factor = 65536;
        end else if (q_hi == q_lo) begin
          factor = 0;
        end else begin
          factor = ((q - q_lo) * 65536) / (q_hi - q_lo);
        end
      end
    end
    for (longint i = 0; i < n; i++) begin
      if (smoothed == 0) begin
        if (rates[i] < rmax_r) rates[i] = rates[i] + 1;
      end else begin
        w = 65536 - (slope_r * i) / n;
        if (w < 0) w = 0;
        sloped = (factor * w) / 65536;
        span = rmax_r - rmin_r;
        rate = rmin_r + ((sloped * span) >>> 16);
        rates[i] = rate[15:0];
      end
    end
    if (gens < 65535) gens++;
    if (gens > lim_r + 1) conv_flag = 1;
    change = sc - prev_score;
    if (change < 0) change = -change;
    if (change < thr_r) begin
      if (stalls < 65535) stalls++;
      if (stalls > win_r) conv_flag = 1;
    end else begin
      stalls = 0;
    end
    a = (gens <= 1) ? 0 : smooth_r;
    if (a > 65536) a = 65536;
    smoothed = (a * sc + (65536 - a) * smoothed) >>> 16;
    prev_score = sc;
    for (longint i = 0; i < n; i++) begin
      r.idx = i[5:0];
      r.rate = rates[i];
      r.conv = conv_flag;
      r.fin = (i + 1 == n);
      rate_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    rate_rec_t e;
    if (rst) begin
      errors = 0;
      clear_state();
      rate_q.delete();
    end else begin
      if (cfg_wr_en) write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_rates(best_score);
      if (out_valid && out_ready) begin
        if (rate_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: idx %0d rate %0d conv %0b last %0b",
                     individual_index, mut_count, converged, last);
        end else begin
          e = rate_q.pop_front();
          if (e.idx !== individual_index || e.rate !== mut_count ||
              e.conv !== converged || e.fin !== last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp idx %0d rate %0d conv %0b last %0b, got %0d %0d %0b %0b",
                       e.idx, e.rate, e.conv, e.fin,
                       individual_index, mut_count, converged, last);
          end
        end
      end
    end
  end

endmodule

/* verif/tb_adaptive_mutation_rate_tuner_top.sv */
`timescale 1ns / 100ps
// Testbench top for the adaptive mutation rate tuner: drives scores and
// register writes under varying idle and output-stall patterns and gives the verdict.
// Depends on amrt_pkg, amrt_checker and the block's RTL.
module tb_adaptive_mutation_rate_tuner_top;
  import amrt_pkg::*;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      cfg_wr_en = 0;
  logic [CFG_IW-1:0]         cfg_index = '0;
  logic [CFG_DW-1:0]         cfg_data = '0;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic signed [SCORE_W-1:0] best_score = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic [IDX_W-1:0]          individual_index;
  logic [RATE_W-1:0]         mut_count;
  logic                      converged;
  logic                      last;
  int                        errors, pending;
  int                        idle_pct = 0, stall_pct = 0;
  logic signed [SCORE_W-1:0] prev_sent = '0;

  always #5 clk = ~clk;

  adaptive_mutation_rate_tuner_top uut (.*);

  amrt_checker chk (.*);

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic write_cfg(logic [CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic send_score(logic signed [SCORE_W-1:0] val);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    best_score <= val;
    prev_sent = val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return prev_sent + $signed($urandom_range(0, 2000)) - 1000;
    if (sel < 55) return prev_sent;
    return $urandom;
  endfunction

  task automatic random_cfg();
    int sel;
    sel = $urandom_range(0, 9);
    write_cfg(REG_POP, sel == 0 ? 0 : sel == 1 ? 64 : sel == 2 ? 127 : $urandom_range(1, 8));
    write_cfg(REG_LIMIT, $urandom_range(0, 1) ? $urandom_range(0, 300) : 65535);
    write_cfg(REG_THR, $urandom_range(0, 2) ? $urandom_range(0, 5000) : $urandom);
    write_cfg(REG_WINDOW, $urandom_range(0, 20));
    write_cfg(REG_RMAX, $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 65535));
    write_cfg(REG_RMIN, $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 65535));
    write_cfg(REG_SLOPE, $urandom_range(0, 131071));
    write_cfg(REG_SMOOTH, $urandom_range(0, 131071));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_score(32'sh8000_0000);
    send_score(32'sh7FFF_FFFF);
    send_score(0);
    send_score(0);
    send_score(-1);
    send_score(1);
    send_score(32'sh0001_0000);
    send_score(32'sh0001_0000);
    send_score(32'sh0001_0100);
    send_score(-32'sh0005_0000);
    send_score(32'sh1234_5678);
    drain();
    write_cfg(REG_POP, 5);
    write_cfg(REG_LIMIT, 0);
    write_cfg(REG_THR, 32'h7FFF_FFFF);
    write_cfg(REG_WINDOW, 0);
    write_cfg(REG_RMAX, 0);
    write_cfg(REG_RMIN, 65535);
    write_cfg(REG_SLOPE, 131071);
    write_cfg(REG_SMOOTH, 65536);
    send_score(32'sh7FFF_FFFF);
    send_score(32'sh8000_0000);
    send_score(5);
    send_score(5);
    send_score(-7);
    drain();
    write_cfg(REG_RMAX, 65535);
    write_cfg(REG_RMIN, 0);
    write_cfg(REG_POP, 127);
    write_cfg(REG_THR, 0);
    send_score(32'sh7FFF_FFFF);
    send_score(32'sh8000_0000);
    send_score(0);
    drain();
    for (int p = 0; p < 8; p++) begin
      idle_pct = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 32 : 0;
      stall_pct = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 32 : 0;
      random_cfg();
      repeat (33) send_score(pick_score());
      drain();
    end
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
